### hw/rtl/l3bm_pkg.sv
// shared types and constants for the three-wire bus master
package l3bm_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned LenWidth    = 16;
  localparam int unsigned CfgIdxWidth = 3;

  // command kinds carried on the mode field
  typedef enum logic [1:0] {
    OP_ADDR  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_END   = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_CLOCK_LOW  = 3'd0,
    CFG_CLOCK_HIGH = 3'd1,
    CFG_HALT       = 3'd2,
    CFG_MODE_SETUP = 3'd3,
    CFG_MODE_HOLD  = 3'd4
  } cfg_reg_e;

  // sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HALT  = 3'd1,
    PH_SETUP = 3'd2,
    PH_LOW   = 3'd3,
    PH_HIGH  = 3'd4,
    PH_HOLD  = 3'd5
  } phase_e;

  // bus pin levels and ownership
  typedef struct packed {
    logic clk;
    logic dat;
    logic mode;
    logic own;
    logic ddrv;
  } pin_t;

  // phase lengths in ticks
  typedef struct packed {
    logic [LenWidth-1:0] clock_low;
    logic [LenWidth-1:0] clock_high;
    logic [LenWidth-1:0] halt;
    logic [LenWidth-1:0] mode_setup;
    logic [LenWidth-1:0] mode_hold;
  } cfg_t;

  // everything reported for one tick
  typedef struct packed {
    pin_t                   pins;
    logic                   cmd_ready;
    logic [BitsPerByte-1:0] read_byte;
    logic                   read_valid;
  } res_t;

endpackage

### hw/rtl/l3bm_seq.sv
// bus sequencer: state registers and the per-tick next-state logic
module l3bm_seq #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic                              cmd_valid_i,
  input  logic [1:0]                        mode_i,
  input  logic [l3bm_pkg::BitsPerByte-1:0]  cmd_byte_i,
  input  logic                              data_line_in_i,
  input  l3bm_pkg::cfg_t                    cfg_i,
  output l3bm_pkg::res_t                    res_o
);

  localparam int unsigned ExtW =
    (TIMER_WIDTH > l3bm_pkg::LenWidth) ? TIMER_WIDTH : l3bm_pkg::LenWidth;
  localparam int unsigned BitW = $clog2(l3bm_pkg::BitsPerByte);

  l3bm_pkg::phase_e                    phase_q, phase_d;
  l3bm_pkg::op_e                       op_q, op_d;
  logic [BitW-1:0]                     bit_q, bit_d;
  logic [l3bm_pkg::BitsPerByte-1:0]    shift_q, shift_d;
  logic [l3bm_pkg::BitsPerByte-1:0]    last_rd_q, last_rd_d;
  logic [1:0]                          seq_cnt_q, seq_cnt_d;
  logic [TIMER_WIDTH-1:0]              timer_q, timer_d;
  l3bm_pkg::pin_t                      pins_q, pins_d;

  logic                                enter;
  l3bm_pkg::phase_e                    enter_ph;
  logic [l3bm_pkg::LenWidth-1:0]       len_sel;
  logic [l3bm_pkg::LenWidth-1:0]       len_m1;
  logic [ExtW-1:0]                     len_ext;
  logic [TIMER_WIDTH-1:0]              len_sat;
  logic [l3bm_pkg::BitsPerByte-1:0]    shift_nxt;
  logic                                ready;
  logic                                rvalid;
  l3bm_pkg::op_e                       cmd_op;

  assign cmd_op = l3bm_pkg::op_e'(mode_i);

  // phase length to timer load: zero acts as one tick, long values saturate
  assign len_m1  = (len_sel == '0) ? '0 : len_sel - 1'b1;
  assign len_ext = ExtW'(len_m1);
  assign len_sat = (len_ext > ExtW'({TIMER_WIDTH{1'b1}})) ? {TIMER_WIDTH{1'b1}}
                                                           : TIMER_WIDTH'(len_ext);

  // next state for one tick
  always_comb begin
    phase_d   = phase_q;
    op_d      = op_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    last_rd_d = last_rd_q;
    seq_cnt_d = seq_cnt_q;
    timer_d   = timer_q;
    pins_d    = pins_q;
    enter     = 1'b0;
    enter_ph  = l3bm_pkg::PH_IDLE;
    len_sel   = cfg_i.mode_setup;
    ready     = 1'b0;
    rvalid    = 1'b0;
    shift_nxt = shift_q >> 1;

    if (phase_q == l3bm_pkg::PH_IDLE) begin
      if (cmd_valid_i) begin
        ready = 1'b1;
        if (cmd_op == l3bm_pkg::OP_END) begin
          pins_d.own  = 1'b0;
          pins_d.ddrv = 1'b0;
          seq_cnt_d   = 2'd0;
        end else if (cmd_op == l3bm_pkg::OP_ADDR) begin
          pins_d    = '{clk: 1'b1, dat: 1'b1, mode: 1'b0, own: 1'b1, ddrv: 1'b1};
          op_d      = l3bm_pkg::OP_ADDR;
          shift_d   = cmd_byte_i;
          bit_d     = '0;
          seq_cnt_d = 2'd1;
          enter     = 1'b1;
          enter_ph  = l3bm_pkg::PH_SETUP;
          len_sel   = cfg_i.mode_setup;
        end else if (pins_q.own) begin
          op_d  = cmd_op;
          bit_d = '0;
          if (cmd_op == l3bm_pkg::OP_WRITE) begin
            shift_d     = cmd_byte_i;
            pins_d.ddrv = 1'b1;
          end else begin
            shift_d     = '0;
            pins_d.ddrv = 1'b0;
          end
          // later data bytes get a mode low pulse first
          if (seq_cnt_q >= 2'd2) begin
            pins_d.mode = 1'b0;
            enter       = 1'b1;
            enter_ph    = l3bm_pkg::PH_HALT;
            len_sel     = cfg_i.halt;
          end else begin
            enter     = 1'b1;
            enter_ph  = l3bm_pkg::PH_SETUP;
            len_sel   = cfg_i.mode_setup;
            seq_cnt_d = seq_cnt_q + 2'd1;
          end
        end
      end
    end else if (timer_q != '0) begin
      timer_d = timer_q - 1'b1;
    end else begin
      unique case (phase_q)
        l3bm_pkg::PH_HALT: begin
          pins_d.mode = 1'b1;
          enter       = 1'b1;
          enter_ph    = l3bm_pkg::PH_SETUP;
          len_sel     = cfg_i.mode_setup;
        end
        l3bm_pkg::PH_SETUP: begin
          pins_d.clk = 1'b0;
          if (op_q != l3bm_pkg::OP_READ) begin
            pins_d.dat = shift_q[0];
          end
          enter    = 1'b1;
          enter_ph = l3bm_pkg::PH_LOW;
          len_sel  = cfg_i.clock_low;
        end
        l3bm_pkg::PH_LOW: begin
          // sample the data line as the clock rises
          if (op_q == l3bm_pkg::OP_READ) begin
            shift_d = {data_line_in_i, shift_q[l3bm_pkg::BitsPerByte-1:1]};
          end
          pins_d.clk = 1'b1;
          enter      = 1'b1;
          enter_ph   = l3bm_pkg::PH_HIGH;
          len_sel    = cfg_i.clock_high;
        end
        l3bm_pkg::PH_HIGH: begin
          if (bit_q == BitW'(l3bm_pkg::BitsPerByte - 1)) begin
            if (op_q == l3bm_pkg::OP_ADDR) begin
              pins_d.mode = 1'b1;
            end
            enter    = 1'b1;
            enter_ph = l3bm_pkg::PH_HOLD;
            len_sel  = cfg_i.mode_hold;
          end else begin
            bit_d      = bit_q + 1'b1;
            pins_d.clk = 1'b0;
            if (op_q != l3bm_pkg::OP_READ) begin
              shift_d    = shift_nxt;
              pins_d.dat = shift_nxt[0];
            end
            enter    = 1'b1;
            enter_ph = l3bm_pkg::PH_LOW;
            len_sel  = cfg_i.clock_low;
          end
        end
        l3bm_pkg::PH_HOLD: begin
          phase_d = l3bm_pkg::PH_IDLE;
          if (op_q == l3bm_pkg::OP_READ) begin
            last_rd_d = shift_q;
            rvalid    = 1'b1;
          end
        end
        default: begin
          phase_d = l3bm_pkg::PH_IDLE;
        end
      endcase
    end

    if (enter) begin
      phase_d = enter_ph;
      timer_d = len_sat;
    end
  end

  // state registers advance once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= l3bm_pkg::PH_IDLE;
      op_q      <= l3bm_pkg::OP_ADDR;
      bit_q     <= '0;
      shift_q   <= '0;
      last_rd_q <= '0;
      seq_cnt_q <= '0;
      timer_q   <= '0;
      pins_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      op_q      <= op_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      last_rd_q <= last_rd_d;
      seq_cnt_q <= seq_cnt_d;
      timer_q   <= timer_d;
      pins_q    <= pins_d;
    end
  end

  // result of this tick
  assign res_o.pins       = pins_d;
  assign res_o.cmd_ready  = ready;
  assign res_o.read_byte  = last_rd_d;
  assign res_o.read_valid = rvalid;

endmodule

### hw/rtl/three_wire_l3_bus_master.sv
// top level of the three-wire bus master: config registers, sequencer, result register
//
// Each input transfer is one bus tick and yields exactly one result transfer
// holding the pin levels, ownership, command acceptance and read data for
// that tick. One tick is taken per clock cycle: the sequencer state is
// updated by a single level of next-state logic, and the result sits in an
// output register, so a new tick is accepted whenever that register is empty
// or being taken in the same cycle. Phase lengths are counted in ticks by a
// TIMER_WIDTH-bit down counter; a length of zero acts as one tick. Commands
// are accepted only between bytes, reported through cmd_ready_o.
module three_wire_l3_bus_master #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [l3bm_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [l3bm_pkg::LenWidth-1:0]       cfg_data_i,
  // tick input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_valid_i,
  input  logic [1:0]                          mode_i,
  input  logic [l3bm_pkg::BitsPerByte-1:0]    cmd_byte_i,
  input  logic                                data_line_in_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                clock_out_o,
  output logic                                data_out_o,
  output logic                                data_drive_o,
  output logic                                mode_out_o,
  output logic                                pins_driven_o,
  output logic                                cmd_ready_o,
  output logic [l3bm_pkg::BitsPerByte-1:0]    read_byte_o,
  output logic                                read_valid_o
);

  localparam logic [l3bm_pkg::LenWidth-1:0] LenReset = l3bm_pkg::LenWidth'(50);

  l3bm_pkg::cfg_t cfg_q;
  l3bm_pkg::res_t res;
  l3bm_pkg::res_t res_q;
  logic           out_valid_q;
  logic           in_xfer;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{LenReset, LenReset, LenReset, LenReset, LenReset};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        l3bm_pkg::CFG_CLOCK_LOW:  cfg_q.clock_low  <= cfg_data_i;
        l3bm_pkg::CFG_CLOCK_HIGH: cfg_q.clock_high <= cfg_data_i;
        l3bm_pkg::CFG_HALT:       cfg_q.halt       <= cfg_data_i;
        l3bm_pkg::CFG_MODE_SETUP: cfg_q.mode_setup <= cfg_data_i;
        l3bm_pkg::CFG_MODE_HOLD:  cfg_q.mode_hold  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // take a tick when the result register is free or draining
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  l3bm_seq #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_xfer),
    .cmd_valid_i    (cmd_valid_i),
    .mode_i         (mode_i),
    .cmd_byte_i     (cmd_byte_i),
    .data_line_in_i (data_line_in_i),
    .cfg_i          (cfg_q),
    .res_o          (res)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign clock_out_o   = res_q.pins.clk;
  assign data_out_o    = res_q.pins.dat;
  assign data_drive_o  = res_q.pins.ddrv;
  assign mode_out_o    = res_q.pins.mode;
  assign pins_driven_o = res_q.pins.own;
  assign cmd_ready_o   = res_q.cmd_ready;
  assign read_byte_o   = res_q.read_byte;
  assign read_valid_o  = res_q.read_valid;

endmodule

### hw/rtl/l3bm_checker.sv
// port-level checks for the three-wire bus master and their bind
module l3bm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                clock_out_o,
  input logic                                data_out_o,
  input logic                                data_drive_o,
  input logic                                mode_out_o,
  input logic                                pins_driven_o,
  input logic                                cmd_ready_o,
  input logic [l3bm_pkg::BitsPerByte-1:0]    read_byte_o,
  input logic                                read_valid_o
);

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o
      && $stable({clock_out_o, data_out_o, data_drive_o, mode_out_o,
                  pins_driven_o, cmd_ready_o, read_byte_o, read_valid_o}))
    else $error("stalled result changed");

  // a command is never taken on the tick a read completes
  a_ready_vs_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> !cmd_ready_o)
    else $error("command accepted while a read completed");

  // data is only driven while the pins are owned
  a_drive_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pins_driven_o |-> !data_drive_o)
    else $error("data driven without pin ownership");

  // a completed read comes from an owned bus with the data drive off
  a_read_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> pins_driven_o && !data_drive_o)
    else $error("read completed with wrong drive state");

endmodule

bind three_wire_l3_bus_master l3bm_checker u_l3bm_checker (.*);

### dv/three_wire_l3_bus_master_checker.sv
// scoreboard for the three-wire bus master: per-tick bus predictor and result compare
module three_wire_l3_bus_master_checker #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [l3bm_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [l3bm_pkg::LenWidth-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                cmd_valid_i,
  input  logic [1:0]                          mode_i,
  input  logic [l3bm_pkg::BitsPerByte-1:0]    cmd_byte_i,
  input  logic                                data_line_in_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic                                clock_out_i,
  input  logic                                data_out_i,
  input  logic                                data_drive_i,
  input  logic                                mode_out_i,
  input  logic                                pins_driven_i,
  input  logic                                cmd_ready_i,
  input  logic [l3bm_pkg::BitsPerByte-1:0]    read_byte_i,
  input  logic                                read_valid_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);

  // predicted sequencer state
  l3bm_pkg::phase_e                  bus_phase;
  l3bm_pkg::op_e                     byte_op;
  logic [2:0]                        bit_pos;
  logic [l3bm_pkg::BitsPerByte-1:0]  shift_q;
  logic [1:0]                        byte_count;
  logic [TIMER_WIDTH-1:0]            phase_left;
  l3bm_pkg::pin_t                    pins;
  logic [l3bm_pkg::BitsPerByte-1:0]  last_rd;
  l3bm_pkg::cfg_t                    timing;

  l3bm_pkg::res_t expected_ticks_q[$];
  int             mismatches;
  int             result_idx;

  // enter a phase; a zero length acts as one tick, long ones saturate the counter
  function automatic void load_phase(l3bm_pkg::phase_e ph,
                                     logic [l3bm_pkg::LenWidth-1:0] len);
    longint unsigned span;
    longint unsigned span_max;
    span_max = (64'd1 << TIMER_WIDTH) - 64'd1;
    span = (len == '0) ? 64'd0 : 64'(len) - 64'd1;
    if (span > span_max) span = span_max;
    bus_phase  = ph;
    phase_left = span[TIMER_WIDTH-1:0];
  endfunction

  // clock falls and, unless reading, the next data bit goes out
  function automatic void start_bit();
    pins.clk = 1'b0;
    if (byte_op != l3bm_pkg::OP_READ) pins.dat = shift_q[0];
    load_phase(l3bm_pkg::PH_LOW, timing.clock_low);
  endfunction

  // advance the predicted bus by one tick and return what it reports
  function automatic l3bm_pkg::res_t next_bus_tick(logic cmd_v, logic [1:0] md,
                                                   logic [l3bm_pkg::BitsPerByte-1:0] cb,
                                                   logic din);
    l3bm_pkg::res_t r;
    l3bm_pkg::op_e  cmd;
    logic           took_cmd;
    logic           rd_done;
    cmd      = l3bm_pkg::op_e'(md);
    took_cmd = 1'b0;
    rd_done  = 1'b0;
    if (bus_phase == l3bm_pkg::PH_IDLE) begin
      if (cmd_v) begin
        took_cmd = 1'b1;
        if (cmd == l3bm_pkg::OP_END) begin
          pins.own   = 1'b0;
          pins.ddrv  = 1'b0;
          byte_count = '0;
        end else if (cmd == l3bm_pkg::OP_ADDR) begin
          pins       = '{clk: 1'b1, dat: 1'b1, mode: 1'b0, own: 1'b1, ddrv: 1'b1};
          byte_op    = l3bm_pkg::OP_ADDR;
          shift_q    = cb;
          bit_pos    = '0;
          byte_count = 2'd1;
          load_phase(l3bm_pkg::PH_SETUP, timing.mode_setup);
        end else if (pins.own) begin
          byte_op = cmd;
          bit_pos = '0;
          if (cmd == l3bm_pkg::OP_WRITE) begin
            shift_q   = cb;
            pins.ddrv = 1'b1;
          end else begin
            shift_q   = '0;
            pins.ddrv = 1'b0;
          end
          // later data bytes get a mode low halt first
          if (byte_count >= 2'd2) begin
            pins.mode = 1'b0;
            load_phase(l3bm_pkg::PH_HALT, timing.halt);
          end else begin
            load_phase(l3bm_pkg::PH_SETUP, timing.mode_setup);
          end
          if (byte_count < 2'd2) byte_count = byte_count + 2'd1;
        end
      end
    end else if (phase_left != '0) begin
      phase_left = phase_left - 1'b1;
    end else begin
      case (bus_phase)
        l3bm_pkg::PH_HALT: begin
          pins.mode = 1'b1;
          load_phase(l3bm_pkg::PH_SETUP, timing.mode_setup);
        end
        l3bm_pkg::PH_SETUP: start_bit();
        l3bm_pkg::PH_LOW: begin
          if (byte_op == l3bm_pkg::OP_READ)
            shift_q = {din, shift_q[l3bm_pkg::BitsPerByte-1:1]};
          pins.clk = 1'b1;
          load_phase(l3bm_pkg::PH_HIGH, timing.clock_high);
        end
        l3bm_pkg::PH_HIGH: begin
          if (bit_pos == 3'(l3bm_pkg::BitsPerByte - 1)) begin
            if (byte_op == l3bm_pkg::OP_ADDR) pins.mode = 1'b1;
            load_phase(l3bm_pkg::PH_HOLD, timing.mode_hold);
          end else begin
            bit_pos = bit_pos + 3'd1;
            if (byte_op != l3bm_pkg::OP_READ) shift_q = shift_q >> 1;
            start_bit();
          end
        end
        l3bm_pkg::PH_HOLD: begin
          bus_phase = l3bm_pkg::PH_IDLE;
          if (byte_op == l3bm_pkg::OP_READ) begin
            last_rd = shift_q;
            rd_done = 1'b1;
          end
        end
        default: bus_phase = l3bm_pkg::PH_IDLE;
      endcase
    end
    r.pins       = pins;
    r.cmd_ready  = took_cmd;
    r.read_byte  = last_rd;
    r.read_valid = rd_done;
    return r;
  endfunction

  // watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin : watch_blk
    l3bm_pkg::res_t seen;
    l3bm_pkg::res_t want;
    if (!rst_ni) begin
      bus_phase  = l3bm_pkg::PH_IDLE;
      byte_op    = l3bm_pkg::OP_ADDR;
      bit_pos    = '0;
      shift_q    = '0;
      byte_count = '0;
      phase_left = '0;
      pins       = '0;
      last_rd    = '0;
      timing     = {5{16'd50}};
      expected_ticks_q.delete();
      mismatches = 0;
      result_idx = 0;
    end else begin
      // result transfer against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        seen.pins       = '{clk: clock_out_i, dat: data_out_i, mode: mode_out_i,
                            own: pins_driven_i, ddrv: data_drive_i};
        seen.cmd_ready  = cmd_ready_i;
        seen.read_byte  = read_byte_i;
        seen.read_valid = read_valid_i;
        if (expected_ticks_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing predicted", result_idx);
        end else begin
          want = expected_ticks_q.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d mismatch", result_idx);
              $display("  want clk=%b dat=%b drv=%b mode=%b own=%b rdy=%b rd=%h rv=%b",
                       want.pins.clk, want.pins.dat, want.pins.ddrv, want.pins.mode,
                       want.pins.own, want.cmd_ready, want.read_byte, want.read_valid);
              $display("  got  clk=%b dat=%b drv=%b mode=%b own=%b rdy=%b rd=%h rv=%b",
                       seen.pins.clk, seen.pins.dat, seen.pins.ddrv, seen.pins.mode,
                       seen.pins.own, seen.cmd_ready, seen.read_byte, seen.read_valid);
            end
          end
        end
        result_idx++;
      end
      // tick transfer into the predictor
      if (in_valid_i && !in_stall_i)
        expected_ticks_q.push_back(next_bus_tick(cmd_valid_i, mode_i, cmd_byte_i,
                                                 data_line_in_i));
      // register writes take effect from the next tick
      if (cfg_we_i) begin
        case (l3bm_pkg::cfg_reg_e'(cfg_index_i))
          l3bm_pkg::CFG_CLOCK_LOW:  timing.clock_low  = cfg_data_i;
          l3bm_pkg::CFG_CLOCK_HIGH: timing.clock_high = cfg_data_i;
          l3bm_pkg::CFG_HALT:       timing.halt       = cfg_data_i;
          l3bm_pkg::CFG_MODE_SETUP: timing.mode_setup = cfg_data_i;
          l3bm_pkg::CFG_MODE_HOLD:  timing.mode_hold  = cfg_data_i;
          default: ;
        endcase
      end
    end
    fail_count_o = mismatches;
    pending_o    = expected_ticks_q.size();
  end

endmodule

### dv/tb_three_wire_l3_bus_master.sv
// testbench top for the three-wire bus master: tick stimulus, stall patterns, verdict
module tb_three_wire_l3_bus_master;

  localparam int          RandomTicks = 400;
  localparam longint      CycleLimit  = 3_000_000;
  localparam int unsigned ByteW       = l3bm_pkg::BitsPerByte;
  localparam int unsigned LenW        = l3bm_pkg::LenWidth;

  typedef struct packed {
    l3bm_pkg::op_e    op;
    logic [ByteW-1:0] payload;
  } bus_cmd_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [l3bm_pkg::CfgIdxWidth-1:0] cfg_index = '0;
  logic [LenW-1:0]                  cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             cmd_valid = 1'b0;
  logic [1:0]                       mode = '0;
  logic [ByteW-1:0]                 cmd_byte = '0;
  logic                             data_line_in = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             clock_out, data_out, data_drive, mode_out, pins_driven;
  logic                             cmd_ready, read_valid;
  logic [ByteW-1:0]                 read_byte;
  int                               fail_count, pending;

  // command script and the tag of each tick in flight
  bus_cmd_t cmd_list[$];
  int       cmd_pos = 0;
  int       offer_tag = -1;
  int       tick_tag_q[$];
  int       ticks_sent = 0;
  int       cmds_taken = 0;
  int       reads_seen = 0;
  int       settings_used = 0;
  longint   cycle_count = 0;

  three_wire_l3_bus_master i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_valid_i    (cmd_valid),
    .mode_i         (mode),
    .cmd_byte_i     (cmd_byte),
    .data_line_in_i (data_line_in),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .clock_out_o    (clock_out),
    .data_out_o     (data_out),
    .data_drive_o   (data_drive),
    .mode_out_o     (mode_out),
    .pins_driven_o  (pins_driven),
    .cmd_ready_o    (cmd_ready),
    .read_byte_o    (read_byte),
    .read_valid_o   (read_valid)
  );

  three_wire_l3_bus_master_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .cmd_valid_i    (cmd_valid),
    .mode_i         (mode),
    .cmd_byte_i     (cmd_byte),
    .data_line_in_i (data_line_in),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .clock_out_i    (clock_out),
    .data_out_i     (data_out),
    .data_drive_i   (data_drive),
    .mode_out_i     (mode_out),
    .pins_driven_i  (pins_driven),
    .cmd_ready_i    (cmd_ready),
    .read_byte_i    (read_byte),
    .read_valid_i   (read_valid),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("three_wire_l3_bus_master verification failed");
      $finish;
    end
  end

  // follow transfers so the script moves on once its command is taken
  always @(posedge clk_i) begin : tag_blk
    int tag;
    if (rst_ni) begin
      if (out_valid && !out_stall && tick_tag_q.size() != 0) begin
        tag = tick_tag_q.pop_front();
        if (cmd_ready) begin
          cmds_taken++;
          if (tag == cmd_pos) cmd_pos++;
        end
        if (read_valid) reads_seen++;
      end
      if (in_valid && !in_stall) begin
        tick_tag_q.push_back(offer_tag);
        ticks_sent++;
      end
    end
  end

  // receiver stalls: changing styles, plus one long hold-off to fill the block
  always @(negedge clk_i) begin : stall_blk
    int stall_style;
    int style_left;
    int hold_left;
    bit held_once;
    if (rst_ni) begin
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!held_once && ticks_sent >= 300) begin
        out_stall <= 1'b1;
        hold_left = 400;
        held_once = 1'b1;
      end else begin
        case (stall_style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= 1'($urandom_range(0, 1));
        endcase
      end
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left  = $urandom_range(20, 120);
      end else begin
        style_left--;
      end
    end
  end

  function automatic void add_cmd(l3bm_pkg::op_e o, logic [ByteW-1:0] v);
    cmd_list.push_back('{op: o, payload: v});
  endfunction

  // mostly well-formed transactions with random content, some broken ones
  function automatic void add_random_transaction();
    int n;
    if ($urandom_range(0, 6) != 0) begin
      n = $urandom_range(1, 4);
      add_cmd(l3bm_pkg::OP_ADDR, ByteW'($urandom));
      for (int k = 0; k < n; k++) begin
        // fresh address inside an open transaction
        if (n > 1 && k == n / 2 && $urandom_range(0, 7) == 0)
          add_cmd(l3bm_pkg::OP_ADDR, ByteW'($urandom));
        add_cmd(($urandom_range(0, 1) != 0) ? l3bm_pkg::OP_WRITE : l3bm_pkg::OP_READ,
                ByteW'($urandom));
      end
      add_cmd(l3bm_pkg::OP_END, ByteW'($urandom));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) add_cmd(l3bm_pkg::op_e'($urandom_range(0, 3)), ByteW'($urandom));
    end
  endfunction

  task automatic write_reg(l3bm_pkg::cfg_reg_e r, logic [LenW-1:0] v);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
  endtask

  task automatic apply_timing(logic [LenW-1:0] lo, logic [LenW-1:0] hi,
                              logic [LenW-1:0] ha, logic [LenW-1:0] su,
                              logic [LenW-1:0] ho);
    write_reg(l3bm_pkg::CFG_CLOCK_LOW, lo);
    write_reg(l3bm_pkg::CFG_CLOCK_HIGH, hi);
    write_reg(l3bm_pkg::CFG_HALT, ha);
    write_reg(l3bm_pkg::CFG_MODE_SETUP, su);
    write_reg(l3bm_pkg::CFG_MODE_HOLD, ho);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // offer ticks in bursts until every scripted command is taken
  task automatic run_cmds();
    int               burst_left;
    int               gap_left;
    bit               took;
    bit               finished;
    bit               nv;
    l3bm_pkg::op_e    nop;
    logic [ByteW-1:0] nb;
    burst_left = $urandom_range(1, 40);
    gap_left   = 0;
    finished   = 1'b0;
    cmd_pos    = 0;
    while (!finished) begin
      @(posedge clk_i);
      took = in_valid && !in_stall;
      @(negedge clk_i);
      // a stalled transfer keeps its payload
      if (!in_valid || took) begin
        if (cmd_pos >= cmd_list.size()) begin
          finished = 1'b1;
          in_valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else begin
          if ($urandom_range(0, 9) != 0) begin
            nv        = 1'b1;
            nop       = cmd_list[cmd_pos].op;
            nb        = cmd_list[cmd_pos].payload;
            offer_tag = cmd_pos;
          end else begin
            // noise tick; never an address so a closed bus stays closed
            nv        = ($urandom_range(0, 3) == 0);
            nop       = l3bm_pkg::op_e'($urandom_range(1, 3));
            nb        = ByteW'($urandom);
            offer_tag = -1;
          end
          in_valid     <= 1'b1;
          cmd_valid    <= nv;
          mode         <= nop;
          cmd_byte     <= nb;
          data_line_in <= 1'($urandom_range(0, 1));
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic run_script();
    run_cmds();
    drain();
    cmd_list.delete();
  endtask

  function automatic logic [LenW-1:0] pick_len();
    return ($urandom_range(0, 7) == 0) ? LenW'($urandom_range(5, 24))
                                       : LenW'($urandom_range(0, 4));
  endfunction

  // stimulus and verdict
  initial begin : main_blk
    int random_start;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset timing, one address byte
    add_cmd(l3bm_pkg::OP_ADDR, 8'hFF);
    add_cmd(l3bm_pkg::OP_END, 8'h00);
    run_script();

    // zero lengths act as one tick; cover every command and the odd orders
    apply_timing('0, '0, '0, '0, '0);
    add_cmd(l3bm_pkg::OP_END, 8'h00);
    add_cmd(l3bm_pkg::OP_WRITE, 8'h12);
    add_cmd(l3bm_pkg::OP_READ, 8'h00);
    add_cmd(l3bm_pkg::OP_ADDR, 8'h00);
    add_cmd(l3bm_pkg::OP_WRITE, 8'hFF);
    add_cmd(l3bm_pkg::OP_READ, 8'h00);
    add_cmd(l3bm_pkg::OP_WRITE, 8'hA5);
    add_cmd(l3bm_pkg::OP_READ, 8'h00);
    add_cmd(l3bm_pkg::OP_ADDR, 8'h5A);
    add_cmd(l3bm_pkg::OP_WRITE, 8'h3C);
    add_cmd(l3bm_pkg::OP_END, 8'hFF);
    run_script();

    // shortest legal lengths, byte count saturation
    apply_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    add_cmd(l3bm_pkg::OP_ADDR, 8'h81);
    add_cmd(l3bm_pkg::OP_READ, 8'h00);
    add_cmd(l3bm_pkg::OP_READ, 8'h00);
    add_cmd(l3bm_pkg::OP_READ, 8'h00);
    add_cmd(l3bm_pkg::OP_END, 8'h00);
    run_script();

    // long halt
    apply_timing('0, '0, 16'd40, '0, '0);
    add_cmd(l3bm_pkg::OP_ADDR, 8'h7E);
    add_cmd(l3bm_pkg::OP_WRITE, 8'h01);
    add_cmd(l3bm_pkg::OP_WRITE, 8'h80);
    add_cmd(l3bm_pkg::OP_END, 8'h00);
    run_script();

    // long setup and hold
    apply_timing(16'd3, 16'd2, '0, 16'd40, 16'd40);
    add_cmd(l3bm_pkg::OP_ADDR, 8'hC3);
    add_cmd(l3bm_pkg::OP_END, 8'h00);
    run_script();

    // random timing settings with random transactions
    random_start = ticks_sent;
    while (ticks_sent - random_start < RandomTicks) begin
      apply_timing(pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
      repeat ($urandom_range(2, 5)) add_random_transaction();
      add_cmd(l3bm_pkg::OP_END, ByteW'($urandom));
      run_script();
    end

    drain();
    repeat (8) @(negedge clk_i);
    $display("covered %0d bus ticks over %0d timing settings", ticks_sent, settings_used);
    $display("%0d commands taken, %0d read bytes returned", cmds_taken, reads_seen);
    if (fail_count == 0) begin
      $display("three_wire_l3_bus_master verification clean");
    end else begin
      $display("three_wire_l3_bus_master verification failed");
    end
    $finish;
  end

endmodule
